// ===== rtl/core/vfre_pkg.sv =====
// shared types, constants and helpers of the frame rate estimator
`timescale 1ns / 1ps
package vfre_pkg;

    localparam int TIME_BITS      = 48;
    localparam int RATE_FRAC_BITS = 8;
    localparam int RATE_W         = 11 + RATE_FRAC_BITS;
    localparam int PLAYER_W       = 10 + RATE_FRAC_BITS;
    localparam int THR_W          = 40;
    localparam int JTI_W          = 24;
    localparam int CNT_W          = 16;
    localparam int JCNT_W         = 8;
    localparam int PROD_W         = CNT_W + 20;
    localparam int NUM_W          = PROD_W + RATE_FRAC_BITS;
    localparam int CFG_W          = 24;
    localparam int CFG_IDX_W      = 1;
    localparam int ID_W           = 32;
    localparam int FIFO_DEPTH     = 4;
    localparam int FIFO_PTR_W     = 2;
    localparam int FIFO_CNT_W     = 3;

    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [RATE_W-1:0]    rate_t;

    localparam logic [CFG_IDX_W-1:0] CFG_PLAYER_FPS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_JUMP_INIT  = 1'b1;

    localparam logic [JTI_W-1:0] JTI_RESET   = JTI_W'(700000);
    localparam logic [THR_W-1:0] THR_MAX     = '1;
    localparam logic [THR_W-1:0] THR_STEP    = THR_W'(1000000);
    localparam time_t            IDLE_GAP    = TIME_BITS'(500000);
    localparam time_t            JUMP_WINDOW = TIME_BITS'(5000000);
    localparam time_t            STEP_SLACK  = TIME_BITS'(1000);
    localparam logic [PROD_W-1:0] USEC_PER_S = PROD_W'(1000000);
    localparam logic [NUM_W-1:0] STEP_NUM    = NUM_W'(1000000) << RATE_FRAC_BITS;
    localparam logic [CNT_W-1:0] CNT_MAX     = '1;
    localparam logic [CNT_W-1:0] MIN_FRAMES  = CNT_W'(10);
    localparam logic [JCNT_W-1:0] JCNT_MAX   = '1;
    localparam logic [JCNT_W-1:0] JCNT_LIMIT = JCNT_W'(5);

    localparam rate_t RATE_MAX = '1;
    localparam rate_t Q_1   = rate_t'(1)   << RATE_FRAC_BITS;
    localparam rate_t Q_27  = rate_t'(27)  << RATE_FRAC_BITS;
    localparam rate_t Q_30  = rate_t'(30)  << RATE_FRAC_BITS;
    localparam rate_t Q_33  = rate_t'(33)  << RATE_FRAC_BITS;
    localparam rate_t Q_55  = rate_t'(55)  << RATE_FRAC_BITS;
    localparam rate_t Q_60  = rate_t'(60)  << RATE_FRAC_BITS;
    localparam rate_t Q_65  = rate_t'(65)  << RATE_FRAC_BITS;
    localparam rate_t Q_120 = rate_t'(120) << RATE_FRAC_BITS;
    localparam rate_t Q_480 = rate_t'(480) << RATE_FRAC_BITS;
    localparam rate_t Q_960 = rate_t'(960) << RATE_FRAC_BITS;

    typedef struct packed {
        logic              mode;
        time_t             timestamp_us;
        time_t             now_us;
        logic              frc_enable;
        logic              has_timestamp;
        logic [ID_W-1:0]   stream_id;
    } in_beat_t;

    typedef struct packed {
        rate_t             fps_q8;
        logic              playing;
        logic              authoritative;
        logic [ID_W-1:0]   report_stream;
        logic              last;
    } out_beat_t;

    typedef enum logic [1:0] {
        SEL_PTS,
        SEL_STEP,
        SEL_WALL
    } div_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PRE,
        ST_MUL,
        ST_PTS,
        ST_PTS_W,
        ST_STEP,
        ST_STEP_W,
        ST_WALL,
        ST_WALL_W,
        ST_POST,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic     load;
        logic     pre;
        logic     mul;
        logic     div_start;
        div_sel_t sel;
        logic     post;
        logic     fin;
    } cmd_t;

    typedef struct packed {
        logic adv;
        logic need_pts;
        logic need_step;
        logic need_wall;
        logic div_done;
        logic room;
    } sts_t;

    // doubles a rate under frame rate conversion, saturating
    function automatic rate_t frc_rate(rate_t x, logic en);
        rate_t r;
        r = x;
        if (en)
        begin
            r = x[RATE_W-1] ? RATE_MAX : (x << 1);
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/vfre_div.sv =====
// restoring serial divider, one quotient bit per cycle, rate saturation
`timescale 1ns / 1ps
module vfre_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [vfre_pkg::NUM_W-1:0]   num,
    input  vfre_pkg::time_t              den,
    output logic                         done,
    output vfre_pkg::rate_t              quo
);
    localparam int T   = vfre_pkg::TIME_BITS;
    localparam int N   = vfre_pkg::NUM_W;
    localparam int CW  = $clog2(N + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [N-1:0]  num_reg, num_next;
    logic [N-1:0]  quo_reg, quo_next;
    logic [T-1:0]  rem_reg, rem_next;
    logic [T-1:0]  den_reg, den_next;
    logic [T:0]    shifted;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        shifted   = {rem_reg, num_reg[N-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            num_next  = num;
            quo_next  = '0;
            rem_next  = '0;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            num_next = num_reg << 1;
            if (shifted >= {1'b0, den_reg})
            begin
                rem_next = T'(shifted - {1'b0, den_reg});
                quo_next = {quo_reg[N-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[T-1:0];
                quo_next = {quo_reg[N-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(N - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = (quo_reg > N'(vfre_pkg::RATE_MAX)) ? vfre_pkg::RATE_MAX
                                                     : quo_reg[vfre_pkg::RATE_W-1:0];

    // a result only appears after a running division
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy_reg)) else $error("divider done without work");
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !start |=> busy_reg || done) else $error("divider lost work");
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !start |-> rem_reg < den_reg) else $error("remainder out of range");

endmodule

// ===== rtl/core/vfre_datapath.sv =====
// estimator state, per-frame update, rate division and result staging
`timescale 1ns / 1ps
module vfre_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  vfre_pkg::cmd_t                   cmd,
    output vfre_pkg::sts_t                   sts,
    input  vfre_pkg::in_beat_t               in_data,
    input  logic                             cfg_we,
    input  logic [vfre_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [vfre_pkg::CFG_W-1:0]       cfg_data,
    input  logic                             room,
    output logic                             push,
    output vfre_pkg::out_beat_t              push_data
);
    localparam int T  = vfre_pkg::TIME_BITS;
    localparam int F  = vfre_pkg::RATE_FRAC_BITS;
    localparam int RW = vfre_pkg::RATE_W;
    localparam int CW = vfre_pkg::CNT_W;

    // configuration
    logic [vfre_pkg::PLAYER_W-1:0] player_reg, player_next;
    logic [vfre_pkg::JTI_W-1:0]    jti_reg, jti_next;

    // estimator state
    vfre_pkg::rate_t              lsr_reg, lsr_next;
    logic [vfre_pkg::THR_W-1:0]   jt_reg, jt_next;
    logic [vfre_pkg::JCNT_W-1:0]  jc_reg, jc_next;
    vfre_pkg::time_t              jws_reg, jws_next;
    vfre_pkg::time_t              lqt_reg, lqt_next;
    logic                         fw_reg, fw_next;
    logic                         rr_reg, rr_next;
    logic [CW-1:0]                tf_reg, tf_next;
    logic [CW-1:0]                wf_reg, wf_next;
    vfre_pkg::rate_t              cr_reg, cr_next;
    vfre_pkg::rate_t              rbp_reg, rbp_next;
    vfre_pkg::rate_t              rbw_reg, rbw_next;
    vfre_pkg::time_t              wws_reg, wws_next;
    vfre_pkg::time_t              pp_reg, pp_next;
    vfre_pkg::time_t              wsp_reg, wsp_next;
    vfre_pkg::time_t              fs_reg, fs_next;
    vfre_pkg::time_t              ms_reg, ms_next;
    logic [CW-1:0]                hits_reg, hits_next;

    // per-item work registers
    vfre_pkg::in_beat_t           in_reg;
    logic                         fc_reg, fc_next;
    logic [CW-1:0]                count_reg, count_next;
    vfre_pkg::time_t              span_reg, span_next;
    vfre_pkg::time_t              wspan_reg, wspan_next;
    logic [vfre_pkg::NUM_W-1:0]   num_reg, num_next;
    logic                         adv_reg, adv_next;
    logic                         npts_reg, npts_next;
    logic                         nstep_reg, nstep_next;
    logic                         nwall_reg, nwall_next;
    logic                         pend_v_reg, pend_v_next;
    vfre_pkg::out_beat_t          pend_reg, pend_next;

    // divider
    logic                         div_done;
    vfre_pkg::rate_t              div_quo;
    logic [vfre_pkg::NUM_W-1:0]   div_num;
    vfre_pkg::time_t              div_den;

    // combinational per-item values
    vfre_pkg::time_t              ts, now_t, pp_e, fs_e, wws_e, wsp_e, diff, jws_e;
    logic                         frc, fc, resend, do_clear, adv_c;
    logic [CW-1:0]                tf1, wf1;
    logic [vfre_pkg::JCNT_W-1:0]  jc1;
    logic [CW+F-1:0]              wq;
    logic [CW+F-1:0]              cr2, cr3;
    logic                         e1_v, e2_v, ep_v;
    vfre_pkg::out_beat_t          e1_d, e2_d, ep_d;
    vfre_pkg::rate_t              rbp_s, chosen, dwp, dcc;
    logic                         use_wall;
    logic [vfre_pkg::PROD_W-1:0]  prod;

    vfre_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_comb
    begin
        unique case (cmd.sel)
            vfre_pkg::SEL_PTS:
            begin
                div_num = num_reg;
                div_den = span_reg;
            end
            vfre_pkg::SEL_STEP:
            begin
                div_num = vfre_pkg::STEP_NUM;
                div_den = ms_reg;
            end
            vfre_pkg::SEL_WALL:
            begin
                div_num = num_reg;
                div_den = wspan_reg;
            end
            default:
            begin
                div_num = num_reg;
                div_den = wspan_reg;
            end
        endcase
    end

    // per-item update
    always_comb
    begin
        player_next = player_reg;
        jti_next    = jti_reg;
        lsr_next = lsr_reg;   jt_next  = jt_reg;   jc_next  = jc_reg;
        jws_next = jws_reg;   lqt_next = lqt_reg;  fw_next  = fw_reg;
        rr_next  = rr_reg;    tf_next  = tf_reg;   wf_next  = wf_reg;
        cr_next  = cr_reg;    rbp_next = rbp_reg;  rbw_next = rbw_reg;
        wws_next = wws_reg;   pp_next  = pp_reg;   wsp_next = wsp_reg;
        fs_next  = fs_reg;    ms_next  = ms_reg;   hits_next = hits_reg;
        fc_next    = fc_reg;
        count_next = count_reg;
        span_next  = span_reg;
        wspan_next = wspan_reg;
        num_next   = num_reg;
        adv_next   = adv_reg;
        npts_next  = npts_reg;
        nstep_next = nstep_reg;
        nwall_next = nwall_reg;
        do_clear = 1'b0;
        adv_c    = 1'b0;
        e1_v = 1'b0;
        e2_v = 1'b0;
        ep_v = 1'b0;
        e1_d = '0;
        e2_d = '0;
        ep_d = '0;

        ts    = in_reg.timestamp_us;
        now_t = in_reg.now_us;
        frc   = in_reg.frc_enable;
        fc    = frc ^ fw_reg;
        resend = (lsr_reg != '0) && (now_t >= lqt_reg) && ((now_t - lqt_reg) >= vfre_pkg::IDLE_GAP);
        tf1 = (tf_reg == vfre_pkg::CNT_MAX) ? tf_reg : tf_reg + CW'(1);
        wf1 = (wf_reg == vfre_pkg::CNT_MAX) ? wf_reg : wf_reg + CW'(1);
        pp_e  = (wf1 == CW'(1)) ? ts : pp_reg;
        fs_e  = (wf1 == CW'(1)) ? ts - pp_reg : fs_reg;
        wws_e = (wf1 == CW'(1)) ? now_t : wws_reg;
        wsp_e = (wf1 == CW'(1)) ? ts : wsp_reg;
        diff  = (ts >= pp_e) ? ts - pp_e : pp_e - ts;
        jc1   = (jc_reg == vfre_pkg::JCNT_MAX) ? jc_reg : jc_reg + vfre_pkg::JCNT_W'(1);
        jws_e = (jws_reg == '0) ? now_t : jws_reg;
        wq    = {wf1, F'(0)};
        cr2   = (CW+F)'(cr_reg) << 1;
        cr3   = cr2 + (CW+F)'(cr_reg);
        prod  = vfre_pkg::PROD_W'(count_reg) * vfre_pkg::USEC_PER_S;

        // rate selection after the divisions
        if (rbp_reg >= vfre_pkg::Q_27 && rbp_reg <= vfre_pkg::Q_33)
        begin
            rbp_s = vfre_pkg::Q_30;
        end
        else if (rbp_reg >= vfre_pkg::Q_55 && rbp_reg <= vfre_pkg::Q_65)
        begin
            rbp_s = vfre_pkg::Q_60;
        end
        else if (rbp_reg > vfre_pkg::Q_960)
        begin
            rbp_s = vfre_pkg::Q_960;
        end
        else
        begin
            rbp_s = rbp_reg;
        end
        dwp = (rbw_reg >= rbp_s) ? rbw_reg - rbp_s : rbp_s - rbw_reg;
        use_wall = (rbp_s >= vfre_pkg::Q_120 && rbp_s <= vfre_pkg::Q_480 && dwp >= vfre_pkg::Q_30)
                || (rbp_s > vfre_pkg::Q_480 && rbp_s <= vfre_pkg::Q_960 && dwp >= vfre_pkg::Q_60);
        chosen = use_wall ? rbw_reg : rbp_s;
        dcc = (chosen >= cr_reg) ? chosen - cr_reg : cr_reg - chosen;

        if (cfg_we)
        begin
            if (cfg_index == vfre_pkg::CFG_PLAYER_FPS)
            begin
                player_next = cfg_data[vfre_pkg::PLAYER_W-1:0];
            end
            else if (cfg_index == vfre_pkg::CFG_JUMP_INIT)
            begin
                jti_next = cfg_data[vfre_pkg::JTI_W-1:0];
                jt_next  = vfre_pkg::THR_W'(cfg_data[vfre_pkg::JTI_W-1:0]);
            end
        end

        if (cmd.pre)
        begin
            fc_next    = fc;
            nwall_next = 1'b0;
            npts_next  = 1'b0;
            nstep_next = 1'b0;
            if (in_reg.mode)
            begin
                // stop: final report, then a clean estimator
                e2_v = (lsr_reg != '0);
                e2_d = '{lsr_reg, 1'b0, (player_reg != '0), in_reg.stream_id, 1'b0};
                lsr_next = '0;
                do_clear = 1'b1;
            end
            else if (in_reg.has_timestamp)
            begin
                e1_v = resend;
                e1_d = '{vfre_pkg::frc_rate(lsr_reg, frc), 1'b1, 1'b1, in_reg.stream_id, 1'b0};
                lqt_next = now_t;
                fw_next  = frc;
                tf_next  = tf1;
                wf_next  = wf1;
                if (ts == '0 && rr_reg && tf1 > vfre_pkg::MIN_FRAMES)
                begin
                    e2_v = (lsr_reg != '0);
                    e2_d = '{lsr_reg, 1'b0, (player_reg != '0), in_reg.stream_id, 1'b0};
                    lsr_next = '0;
                    do_clear = 1'b1;
                end
                else if (player_reg != '0)
                begin
                    if (!rr_reg || fc)
                    begin
                        e2_v = 1'b1;
                        e2_d = '{vfre_pkg::frc_rate(RW'(player_reg), frc), 1'b1, 1'b1,
                                 in_reg.stream_id, 1'b0};
                        cr_next  = RW'(player_reg);
                        lsr_next = RW'(player_reg);
                        rr_next  = 1'b1;
                        wf_next  = '0;
                    end
                end
                else if (ts == '0)
                begin
                    wf_next = '0;
                end
                else if (wf1 == CW'(1) && !(ts > pp_reg && pp_reg != '0))
                begin
                    pp_next = ts;
                    wf_next = '0;
                end
                else
                begin
                    if (wf1 == CW'(1))
                    begin
                        fs_next  = fs_e;
                        wws_next = now_t;
                        pp_next  = ts;
                        wsp_next = ts;
                    end
                    if (64'(diff) >= 64'(jt_reg))
                    begin
                        // timestamp jump
                        do_clear = 1'b1;
                        if (jc1 > vfre_pkg::JCNT_LIMIT && now_t >= jws_e
                            && (now_t - jws_e) > vfre_pkg::JUMP_WINDOW)
                        begin
                            jt_next  = (jt_reg > vfre_pkg::THR_MAX - vfre_pkg::THR_STEP)
                                       ? vfre_pkg::THR_MAX : jt_reg + vfre_pkg::THR_STEP;
                            jc_next  = '0;
                            jws_next = '0;
                        end
                        else
                        begin
                            jc_next  = jc1;
                            jws_next = jws_e;
                        end
                    end
                    else
                    begin
                        // smallest step tracking
                        if (ms_reg == '0)
                        begin
                            ms_next = diff;
                        end
                        else if (diff > ms_reg)
                        begin
                            if (diff - ms_reg == vfre_pkg::STEP_SLACK)
                            begin
                                hits_next = (hits_reg == vfre_pkg::CNT_MAX) ? hits_reg
                                            : hits_reg + CW'(1);
                            end
                        end
                        else if (diff == ms_reg)
                        begin
                            hits_next = (hits_reg == vfre_pkg::CNT_MAX) ? hits_reg
                                        : hits_reg + CW'(1);
                        end
                        else
                        begin
                            ms_next   = diff;
                            hits_next = CW'(1);
                        end

                        adv_c = fc;
                        if (ts > pp_e)
                        begin
                            if ((ts - pp_e == fs_e || fs_e == '0) && wq >= cr2)
                            begin
                                adv_c = 1'b1;
                            end
                            if (!rr_reg && wq >= cr3)
                            begin
                                adv_c = 1'b1;
                            end
                        end
                        pp_next = ts;
                        if (adv_c)
                        begin
                            span_next  = ts - wsp_e;
                            wspan_next = now_t - wws_e;
                            count_next = wf1 - CW'(1);
                            wf_next    = '0;
                            wsp_next   = ts;
                            wws_next   = now_t;
                            rbw_next   = (wf1 != CW'(1)) ? vfre_pkg::RATE_MAX : '0;
                            if (hits_next != '0)
                            begin
                                nstep_next = (ms_next != '0);
                                if (ms_next == '0)
                                begin
                                    rbp_next = '0;
                                end
                            end
                            else
                            begin
                                npts_next = (ts != wsp_e);
                            end
                            nwall_next = (now_t != wws_e);
                        end
                    end
                end
            end
            adv_next = adv_c;
        end

        if (cmd.mul)
        begin
            num_next = {prod, F'(0)};
        end

        if (div_done)
        begin
            unique case (cmd.sel)
                vfre_pkg::SEL_PTS:  rbp_next = div_quo;
                vfre_pkg::SEL_STEP: rbp_next = div_quo;
                vfre_pkg::SEL_WALL: rbw_next = div_quo;
                default:            rbw_next = rbw_reg;
            endcase
        end

        if (cmd.post)
        begin
            rbp_next = rbp_s;
            if (rbw_reg != '0 || rbp_s != '0)
            begin
                if ((chosen != '0 && !rr_reg) || dcc >= vfre_pkg::Q_1 || fc_reg)
                begin
                    ep_v = 1'b1;
                    ep_d = '{vfre_pkg::frc_rate(chosen, in_reg.frc_enable), 1'b1, 1'b0,
                             in_reg.stream_id, 1'b0};
                    rr_next  = 1'b1;
                    cr_next  = chosen;
                    lsr_next = chosen;
                end
                else
                begin
                    lsr_next = cr_reg;
                end
            end
        end

        if (do_clear)
        begin
            rr_next = 1'b0;   tf_next = '0;    wf_next = '0;
            cr_next = vfre_pkg::Q_30;
            rbp_next = '0;    rbw_next = '0;   wws_next = '0;
            pp_next = '0;     wsp_next = '0;   fs_next = '0;
            ms_next = '0;     hits_next = '0;
        end
    end

    // result staging: the newest result waits so its last flag can be set
    always_comb
    begin
        push        = 1'b0;
        push_data   = pend_reg;
        pend_v_next = pend_v_reg;
        pend_next   = pend_reg;
        if (cmd.pre)
        begin
            if (e1_v && e2_v)
            begin
                push        = 1'b1;
                push_data   = e1_d;
                pend_v_next = 1'b1;
                pend_next   = e2_d;
            end
            else if (e1_v)
            begin
                pend_v_next = 1'b1;
                pend_next   = e1_d;
            end
            else if (e2_v)
            begin
                pend_v_next = 1'b1;
                pend_next   = e2_d;
            end
        end
        else if (cmd.post && ep_v)
        begin
            push        = pend_v_reg;
            push_data   = pend_reg;
            pend_v_next = 1'b1;
            pend_next   = ep_d;
        end
        else if (cmd.fin && pend_v_reg)
        begin
            push           = 1'b1;
            push_data      = pend_reg;
            push_data.last = 1'b1;
            pend_v_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            player_reg <= '0;
            jti_reg    <= vfre_pkg::JTI_RESET;
            lsr_reg    <= '0;
            jt_reg     <= vfre_pkg::THR_W'(vfre_pkg::JTI_RESET);
            jc_reg     <= '0;
            jws_reg    <= '0;
            lqt_reg    <= '0;
            fw_reg     <= 1'b0;
            rr_reg     <= 1'b0;
            tf_reg     <= '0;
            wf_reg     <= '0;
            cr_reg     <= vfre_pkg::Q_30;
            rbp_reg    <= '0;
            rbw_reg    <= '0;
            wws_reg    <= '0;
            pp_reg     <= '0;
            wsp_reg    <= '0;
            fs_reg     <= '0;
            ms_reg     <= '0;
            hits_reg   <= '0;
            pend_v_reg <= 1'b0;
            adv_reg    <= 1'b0;
            npts_reg   <= 1'b0;
            nstep_reg  <= 1'b0;
            nwall_reg  <= 1'b0;
            fc_reg     <= 1'b0;
        end
        else
        begin
            player_reg <= player_next;
            jti_reg    <= jti_next;
            lsr_reg    <= lsr_next;
            jt_reg     <= jt_next;
            jc_reg     <= jc_next;
            jws_reg    <= jws_next;
            lqt_reg    <= lqt_next;
            fw_reg     <= fw_next;
            rr_reg     <= rr_next;
            tf_reg     <= tf_next;
            wf_reg     <= wf_next;
            cr_reg     <= cr_next;
            rbp_reg    <= rbp_next;
            rbw_reg    <= rbw_next;
            wws_reg    <= wws_next;
            pp_reg     <= pp_next;
            wsp_reg    <= wsp_next;
            fs_reg     <= fs_next;
            ms_reg     <= ms_next;
            hits_reg   <= hits_next;
            pend_v_reg <= pend_v_next;
            adv_reg    <= adv_next;
            npts_reg   <= npts_next;
            nstep_reg  <= nstep_next;
            nwall_reg  <= nwall_next;
            fc_reg     <= fc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            in_reg <= in_data;
        end
        pend_reg  <= pend_next;
        count_reg <= count_next;
        span_reg  <= span_next;
        wspan_reg <= wspan_next;
        num_reg   <= num_next;
    end

    assign sts.adv       = adv_c;
    assign sts.need_pts  = npts_reg;
    assign sts.need_step = nstep_reg;
    assign sts.need_wall = nwall_reg;
    assign sts.div_done  = div_done;
    assign sts.room      = room;

    // a stop leaves the rate estimate idle
    a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pre && in_reg.mode |=> !rr_reg && lsr_reg == '0) else $error("stop left state");
    a_fin_flushes: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fin |=> !pend_v_reg) else $error("result left staged");
    a_step_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start && cmd.sel == vfre_pkg::SEL_STEP |-> ms_reg != '0)
        else $error("division by zero step");

endmodule

// ===== rtl/core/vfre_ctrl.sv =====
// sequencer for one item: update, multiply, up to two divisions, report
`timescale 1ns / 1ps
module vfre_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  vfre_pkg::sts_t  sts,
    output vfre_pkg::cmd_t  cmd
);
    vfre_pkg::state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            vfre_pkg::ST_IDLE:
            begin
                if (in_valid && sts.room)
                begin
                    state_next = vfre_pkg::ST_PRE;
                end
            end
            vfre_pkg::ST_PRE:
            begin
                state_next = sts.adv ? vfre_pkg::ST_MUL : vfre_pkg::ST_FIN;
            end
            vfre_pkg::ST_MUL:
            begin
                priority if (sts.need_pts)
                begin
                    state_next = vfre_pkg::ST_PTS;
                end
                else if (sts.need_step)
                begin
                    state_next = vfre_pkg::ST_STEP;
                end
                else if (sts.need_wall)
                begin
                    state_next = vfre_pkg::ST_WALL;
                end
                else
                begin
                    state_next = vfre_pkg::ST_POST;
                end
            end
            vfre_pkg::ST_PTS:    state_next = vfre_pkg::ST_PTS_W;
            vfre_pkg::ST_STEP:   state_next = vfre_pkg::ST_STEP_W;
            vfre_pkg::ST_WALL:   state_next = vfre_pkg::ST_WALL_W;
            vfre_pkg::ST_PTS_W, vfre_pkg::ST_STEP_W:
            begin
                if (sts.div_done)
                begin
                    state_next = sts.need_wall ? vfre_pkg::ST_WALL : vfre_pkg::ST_POST;
                end
            end
            vfre_pkg::ST_WALL_W:
            begin
                if (sts.div_done)
                begin
                    state_next = vfre_pkg::ST_POST;
                end
            end
            vfre_pkg::ST_POST:   state_next = vfre_pkg::ST_FIN;
            vfre_pkg::ST_FIN:    state_next = vfre_pkg::ST_IDLE;
            default:             state_next = vfre_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        cmd.sel  = vfre_pkg::SEL_PTS;
        in_ready = 1'b0;
        unique case (state_reg)
            vfre_pkg::ST_IDLE:
            begin
                in_ready = sts.room;
                cmd.load = in_valid && sts.room;
            end
            vfre_pkg::ST_PRE:    cmd.pre = 1'b1;
            vfre_pkg::ST_MUL:    cmd.mul = 1'b1;
            vfre_pkg::ST_PTS:
            begin
                cmd.div_start = 1'b1;
                cmd.sel       = vfre_pkg::SEL_PTS;
            end
            vfre_pkg::ST_PTS_W:  cmd.sel = vfre_pkg::SEL_PTS;
            vfre_pkg::ST_STEP:
            begin
                cmd.div_start = 1'b1;
                cmd.sel       = vfre_pkg::SEL_STEP;
            end
            vfre_pkg::ST_STEP_W: cmd.sel = vfre_pkg::SEL_STEP;
            vfre_pkg::ST_WALL:
            begin
                cmd.div_start = 1'b1;
                cmd.sel       = vfre_pkg::SEL_WALL;
            end
            vfre_pkg::ST_WALL_W: cmd.sel = vfre_pkg::SEL_WALL;
            vfre_pkg::ST_POST:   cmd.post = 1'b1;
            vfre_pkg::ST_FIN:    cmd.fin = 1'b1;
            default:             cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vfre_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == vfre_pkg::ST_PRE) else $error("accept lost");
    a_single_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.pre, cmd.mul, cmd.div_start, cmd.post, cmd.fin}))
        else $error("overlapping commands");
    a_fin_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fin |=> state_reg == vfre_pkg::ST_IDLE) else $error("fin did not end item");

endmodule

// ===== rtl/core/video_frame_rate_estimator_unit.sv =====
// top level of the video frame rate estimator with its result queue
`timescale 1ns / 1ps
// Frame rate estimator: each frame beat (mode 0) updates window counts,
// smallest-step tracking and timestamp jump detection, and may produce up to
// two report beats; a stop beat (mode 1) reports the last rate as stopped and
// clears the estimator. An item that closes no window goes through the update
// and finish steps only; one that closes a window also goes through the
// multiply, each serial division it needs (timestamp or step rate, and wall
// rate) and the report step; a beat is taken only once the last is done. The
// single shared divider, restoring, one quotient bit per cycle over 44 bits.
// Reports go through a four-deep queue, so new beats are
// taken while earlier reports still wait at the output; a beat is taken only
// when the queue has room for the two reports it may cause. Rates are Q11.8,
// config writes are accepted any time the block is idle.
module video_frame_rate_estimator_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  vfre_pkg::in_beat_t               in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output vfre_pkg::out_beat_t              out_data,
    input  logic                             cfg_we,
    input  logic [vfre_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [vfre_pkg::CFG_W-1:0]       cfg_data
);
    localparam int PW = vfre_pkg::FIFO_PTR_W;
    localparam int QW = vfre_pkg::FIFO_CNT_W;

    vfre_pkg::cmd_t      cmd;
    vfre_pkg::sts_t      sts;
    logic                push;
    vfre_pkg::out_beat_t push_data;
    logic                room;
    logic                pop;

    // report queue
    vfre_pkg::out_beat_t fifo_reg [vfre_pkg::FIFO_DEPTH];
    logic [PW-1:0]       wr_reg, wr_next;
    logic [PW-1:0]       rd_reg, rd_next;
    logic [QW-1:0]       cnt_reg, cnt_next;

    vfre_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    vfre_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .room      (room),
        .push      (push),
        .push_data (push_data)
    );

    // room for the two reports a beat can cause
    assign room      = cnt_reg <= QW'(vfre_pkg::FIFO_DEPTH - 2);
    assign out_valid = cnt_reg != '0;
    assign out_data  = fifo_reg[rd_reg];
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_next  = push ? wr_reg + PW'(1) : wr_reg;
        rd_next  = pop ? rd_reg + PW'(1) : rd_reg;
        cnt_next = cnt_reg + QW'(push) - QW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_reg] <= push_data;
        end
    end

    // the queue never overflows and its count tracks the pointers
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> cnt_reg < QW'(vfre_pkg::FIFO_DEPTH) || pop) else $error("queue overflow");
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QW'(vfre_pkg::FIFO_DEPTH)) else $error("queue count out of range");
    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        PW'(cnt_reg) == PW'(wr_reg - rd_reg)) else $error("queue pointers disagree");

endmodule
